// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a property holds on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a property holds on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/core/svc_pkg.sv =====
// ----------------------------------------------------------------------------
// svc_pkg
// Types and constants for the steering vector correlator.
// ----------------------------------------------------------------------------
package svc_pkg;
    localparam int GRID_CELLS_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int ANTENNAS        = 4;
    localparam int ANT_W           = 2;
    localparam int CELL_W          = 10;
    localparam int VAL_W           = 16;
    localparam int MAG_W           = 32;

    localparam logic [1:0] OP_WR_REF  = 2'd0;
    localparam logic [1:0] OP_WR_MEAS = 2'd1;
    localparam logic [1:0] OP_CORR    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_SQ,
        ST_SQRT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [CELL_W-1:0]  cell_req;
        logic [ANT_W-1:0]   antenna;
        logic signed [VAL_W-1:0] value_re;
        logic signed [VAL_W-1:0] value_im;
    } in_item_t;

    typedef struct packed {
        logic [CELL_W-1:0] result_cell;
        logic [MAG_W-1:0]  magnitude;
    } out_item_t;
endpackage

// ===== rtl/core/svc_if.sv =====
// ----------------------------------------------------------------------------
// svc_in_if / svc_out_if
// Valid/ready channels carrying correlator items.
// ----------------------------------------------------------------------------
interface svc_in_if;
    import svc_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface svc_out_if;
    import svc_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/svc_ram.sv =====
// ----------------------------------------------------------------------------
// svc_ram
// Single-port write, single-port read RAM with registered read data.
// ----------------------------------------------------------------------------
module svc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/steering_vector_correlator.sv =====
// Sequence: a correlation transfer is followed by reference reads and
//   accumulation per antenna, absolute values and then squares, the
//   bit-by-bit root steps, then the output register load.
// Throughput: writes 1 per cycle while idle; one correlation at a time, input stalls
//   until its result transfer (iterative root, single reference read port).
// Reset: measured values clear to zero, control idles; reference RAM not cleared.
// ----------------------------------------------------------------------------
// steering_vector_correlator
// Correlates a stored reference steering vector against the latest measured
// I/Q value of each antenna and reports the magnitude of the sums divided by four.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module steering_vector_correlator #(
    parameter int GRID_CELLS  = svc_pkg::GRID_CELLS_DEF,
    parameter int SAMPLE_BITS = svc_pkg::SAMPLE_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    svc_in_if.sink    in_ch,
    svc_out_if.source out_ch
);
    import svc_pkg::*;

    localparam int CW    = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
    localparam int AW    = CW + ANT_W;
    localparam int DEPTH = GRID_CELLS * ANTENNAS;
    localparam int EW    = 2 * SAMPLE_BITS;
    // product 2S bits, sum of 8 products fits in 2S+3
    localparam int SW    = 2 * SAMPLE_BITS + 3;
    localparam int QW    = SW - 2;                 // after shift
    localparam int MW    = 2 * QW;                 // squared sum width (+1 below)
    localparam int RSTEP = (MW + 2) / 2;           // root bits
    localparam int NW    = 2 * RSTEP;
    localparam int KW    = $clog2(RSTEP + 1);

    // Reference memory: {re, im} per (cell, antenna).
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    svc_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ref_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    logic signed [SAMPLE_BITS-1:0] meas_re_reg [ANTENNAS];
    logic signed [SAMPLE_BITS-1:0] meas_im_reg [ANTENNAS];

    state_t state_reg, state_next;
    logic [ANT_W:0]        cnt_reg, cnt_next;       // read index 0..4
    logic                  rvalid_reg;              // ram data valid
    logic [ANT_W-1:0]      rant_reg;                // antenna of ram data
    logic                  inrange_reg;
    logic [CELL_W-1:0]     cell_reg;
    logic [CW-1:0]         caddr_reg;
    logic signed [SW-1:0]  sre_reg, sim_reg;
    logic [NW-1:0]         num_reg;
    logic [NW-1:0]         root_reg;
    logic [NW-1:0]         bit_reg;
    logic [KW-1:0]         k_reg;
    logic [QW-1:0]         are_reg, aim_reg;
    logic [MAG_W-1:0]      mag_reg;
    logic                  sq_phase_reg;

    logic in_xfer, out_xfer;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign out_xfer    = out_ch.valid && out_ch.ready;

    in_item_t it;
    assign it = in_ch.data;

    // Field bits above SAMPLE_BITS are dropped; a narrower field is zero-padded.
    logic signed [SAMPLE_BITS-1:0] v_re, v_im;
    assign v_re = SAMPLE_BITS'(unsigned'(it.value_re));
    assign v_im = SAMPLE_BITS'(unsigned'(it.value_im));

    logic in_cell_ok;
    assign in_cell_ok = ({22'd0, it.cell_req} < 32'(GRID_CELLS));

    // Reference write port.
    assign ram_we    = in_xfer && (it.opcode == OP_WR_REF) && in_cell_ok;
    assign ram_waddr = {CW'(it.cell_req), it.antenna};
    assign ram_wdata = {v_re, v_im};
    assign ram_raddr = {caddr_reg, cnt_reg[ANT_W-1:0]};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_xfer && it.opcode == OP_CORR) state_next = ST_ACC;
            ST_ACC:  if (rvalid_reg && rant_reg == ANT_W'(ANTENNAS - 1))
                         state_next = ST_SQ;
            ST_SQ:   if (sq_phase_reg) state_next = ST_SQRT;
            ST_SQRT: if (k_reg == '0) state_next = ST_OUT;
            ST_OUT:  if (out_xfer) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (state_reg == ST_IDLE)
        begin
            cnt_next = '0;
        end
        else if (state_reg == ST_ACC && cnt_reg != (ANT_W+1)'(ANTENNAS))
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    // Multiply-accumulate of one antenna per cycle.
    logic signed [SAMPLE_BITS-1:0] ra, rb, mc, md;
    logic signed [EW-1:0] p_ac, p_bd, p_bc, p_ad;
    logic signed [EW:0] p_re, p_im;
    assign ra = ram_rdata[EW-1:SAMPLE_BITS];
    assign rb = ram_rdata[SAMPLE_BITS-1:0];
    assign mc = meas_re_reg[rant_reg];
    assign md = meas_im_reg[rant_reg];
    assign p_ac = ra * mc;
    assign p_bd = rb * md;
    assign p_bc = rb * mc;
    assign p_ad = ra * md;
    assign p_re = (EW+1)'(p_ac) + (EW+1)'(p_bd);
    assign p_im = (EW+1)'(p_bc) - (EW+1)'(p_ad);

    logic signed [QW-1:0] q_re, q_im;
    assign q_re = QW'(sre_reg >>> 2);
    assign q_im = QW'(sim_reg >>> 2);

    // Square-root step.
    logic [NW-1:0] trial;
    assign trial = root_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cnt_reg    <= '0;
            rvalid_reg <= 1'b0;
            for (int i = 0; i < ANTENNAS; i++)
            begin
                meas_re_reg[i] <= '0;
                meas_im_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            rvalid_reg <= (state_reg == ST_ACC) && (cnt_reg != (ANT_W+1)'(ANTENNAS));
            if (in_xfer && it.opcode == OP_WR_MEAS)
            begin
                meas_re_reg[it.antenna] <= v_re;
                meas_im_reg[it.antenna] <= v_im;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rant_reg <= cnt_reg[ANT_W-1:0];
        if (in_xfer)
        begin
            cell_reg    <= it.cell_req;
            caddr_reg   <= CW'(it.cell_req);
            inrange_reg <= in_cell_ok;
            sre_reg     <= '0;
            sim_reg     <= '0;
            sq_phase_reg <= 1'b0;
        end
        if (state_reg == ST_ACC && rvalid_reg && inrange_reg)
        begin
            sre_reg <= sre_reg + SW'(p_re);
            sim_reg <= sim_reg + SW'(p_im);
        end
        if (state_reg == ST_SQ)
        begin
            sq_phase_reg <= 1'b1;
            if (!sq_phase_reg)
            begin
                are_reg   <= q_re[QW-1] ? QW'(-q_re) : QW'(q_re);
                aim_reg   <= q_im[QW-1] ? QW'(-q_im) : QW'(q_im);
            end
            else
            begin
                // both squares and their sum in the same cycle
                num_reg   <= NW'(MW'(are_reg) * MW'(are_reg))
                           + NW'(MW'(aim_reg) * MW'(aim_reg));
                root_reg  <= '0;
                bit_reg   <= NW'(1) << (NW - 2);
                k_reg     <= KW'(RSTEP);
            end
        end
        if (state_reg == ST_SQRT && k_reg != '0)
        begin
            if (num_reg >= trial)
            begin
                num_reg  <= num_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
            k_reg   <= k_reg - 1'b1;
        end
        if (state_reg == ST_SQRT && k_reg == '0)
        begin
            mag_reg <= (root_reg > NW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                     : MAG_W'(root_reg);
        end
    end

    assign out_ch.valid            = (state_reg == ST_OUT);
    assign out_ch.data.result_cell = cell_reg;
    assign out_ch.data.magnitude   = mag_reg;

    `ASSERT_CLK(a_busy_no_accept, clk, rst_n, (state_reg != ST_IDLE) |-> !in_ch.ready,
        "input accepted while busy")
    `ASSERT_CLK(a_out_only_done, clk, rst_n, out_ch.valid |-> (state_reg == ST_OUT),
        "result shown outside output state")
    `ASSERT_CLK(a_corr_starts, clk, rst_n,
        (in_xfer && it.opcode == OP_CORR) |=> (state_reg == ST_ACC),
        "correlation did not start")
endmodule

// ===== dv/steering_vector_correlator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// steering_vector_correlator_tb
// Self-checking bench: drives reference, measurement, correlation and unused-opcode
// transfers with random gaps and backpressure, predicts each magnitude.
// ----------------------------------------------------------------------------
module steering_vector_correlator_tb;
    import svc_pkg::*;

    logic clk;
    logic rst_n;

    svc_in_if  in_ch ();
    svc_out_if out_ch ();

    steering_vector_correlator i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Predictor state: reference table, written-flags and latest measurements.
    logic signed [VAL_W-1:0] ref_re [GRID_CELLS_DEF*ANTENNAS];
    logic signed [VAL_W-1:0] ref_im [GRID_CELLS_DEF*ANTENNAS];
    bit                      ref_written [GRID_CELLS_DEF];  // all 4 antennas written
    logic signed [VAL_W-1:0] meas_re [ANTENNAS];
    logic signed [VAL_W-1:0] meas_im [ANTENNAS];

    out_item_t expected_results[$];
    int        error_count;
    int        items_sent;
    int        results_seen;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Floor of the square root of a 64-bit value, bit by bit.
    function automatic logic [31:0] root_floor(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        for (int i = 31; i >= 0; i--)
        begin
            b = r | (64'd1 << i);
            if (b * b <= n)
                r = b;
        end
        return r[31:0];
    endfunction

    // Apply one transfer to the predictor; push the result of a correlation.
    task automatic predict_transfer(input in_item_t it);
        longint    acc_re;
        longint    acc_im;
        longint    a, b, c, d;
        int        idx;
        out_item_t res;
        acc_re = 0;
        acc_im = 0;
        case (it.opcode)
            OP_WR_REF:
            begin
                idx = it.cell_req * ANTENNAS + it.antenna;
                ref_re[idx] = it.value_re;
                ref_im[idx] = it.value_im;
            end
            OP_WR_MEAS:
            begin
                meas_re[it.antenna] = it.value_re;
                meas_im[it.antenna] = it.value_im;
            end
            OP_CORR:
            begin
                for (int k = 0; k < ANTENNAS; k++)
                begin
                    idx = it.cell_req * ANTENNAS + k;
                    a = ref_re[idx];
                    b = ref_im[idx];
                    c = meas_re[k];
                    d = meas_im[k];
                    acc_re += a * c + b * d;
                    acc_im += b * c - a * d;
                end
                // arithmetic shift == floor divide by four
                acc_re = acc_re >>> 2;
                acc_im = acc_im >>> 2;
                res.result_cell = it.cell_req;
                res.magnitude   = root_floor(acc_re * acc_re + acc_im * acc_im);
                expected_results.push_back(res);
            end
            default:
            begin
            end
        endcase
    endtask

    // Send one transfer after a random gap; update the predictor on acceptance.
    // Valid stays high after the transfer until the next call or a drain.
    task automatic send_item(input in_item_t it);
        int gap;
        gap = $urandom_range(0, 13);
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_transfer(it);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_ref(input int cell_idx, input int ant,
                             input logic [15:0] re, input logic [15:0] im);
        in_item_t it;
        it.opcode   = OP_WR_REF;
        it.cell_req = CELL_W'(cell_idx);
        it.antenna  = ANT_W'(ant);
        it.value_re = re;
        it.value_im = im;
        send_item(it);
    endtask

    task automatic write_meas(input int ant, input logic [15:0] re, input logic [15:0] im);
        in_item_t it;
        it.opcode   = OP_WR_MEAS;
        it.cell_req = CELL_W'($urandom);   // unused field, random content
        it.antenna  = ANT_W'(ant);
        it.value_re = re;
        it.value_im = im;
        send_item(it);
    endtask

    // Fill all four antennas of a cell so it may be correlated.
    task automatic fill_cell(input int cell_idx, input bit extreme);
        for (int k = 0; k < ANTENNAS; k++)
        begin
            if (extreme)
                write_ref(cell_idx, k, ($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF),
                          ($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF));
            else
                write_ref(cell_idx, k, 16'($urandom), 16'($urandom));
        end
        ref_written[cell_idx] = 1'b1;
    endtask

    task automatic correlate(input int cell_idx);
        in_item_t it;
        it.opcode   = OP_CORR;
        it.cell_req = CELL_W'(cell_idx);
        it.antenna  = ANT_W'($urandom);
        it.value_re = VAL_W'($urandom);
        it.value_im = VAL_W'($urandom);
        send_item(it);
    endtask

    // Hold the sender until every expected result has come back.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // Directed: extremes, zero measurements, edge cells, opcode 3, unused fields.
    task automatic test_directed();
        in_item_t it;
        fill_cell(0, 1'b1);
        correlate(0);                     // measurements still zero after reset
        fill_cell(GRID_CELLS_DEF - 1, 1'b1);
        for (int k = 0; k < ANTENNAS; k++)
            write_meas(k, 16'h8000, 16'h8000);
        correlate(0);
        correlate(GRID_CELLS_DEF - 1);
        for (int k = 0; k < ANTENNAS; k++)
            write_meas(k, 16'h7FFF, 16'h8000);
        correlate(GRID_CELLS_DEF - 1);
        it = '1;                          // unused opcode, all fields high
        send_item(it);
        it = '0;
        it.opcode = 2'd3;
        send_item(it);
        correlate(0);
        drain_results();
    endtask

    // Random: mostly fill-measure-correlate sequences on a small set of cells.
    task automatic test_random();
        int cell_idx;
        int sel;
        while (items_sent < 1000)
        begin
            sel      = $urandom_range(0, 99);
            cell_idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, GRID_CELLS_DEF - 1)
                                                   : $urandom_range(0, 15);
            if (sel < 20)
                fill_cell(cell_idx, $urandom_range(0, 7) == 0);
            else if (sel < 45)
                write_meas($urandom_range(0, 3), 16'($urandom), 16'($urandom));
            else if (sel < 90)
            begin
                if (!ref_written[cell_idx])
                    fill_cell(cell_idx, 1'b0);
                correlate(cell_idx);
            end
            else if (sel < 95)
            begin
                if (ref_written[cell_idx])
                    write_ref(cell_idx, $urandom_range(0, 3), 16'($urandom), 16'($urandom));
            end
            else
            begin
                in_item_t it;
                it.opcode   = 2'd3;
                it.cell_req = CELL_W'($urandom);
                it.antenna  = ANT_W'($urandom);
                it.value_re = VAL_W'($urandom);
                it.value_im = VAL_W'($urandom);
                send_item(it);
            end
            if (items_sent == 500)
                drain_results();
        end
    endtask

    // Result checker with random backpressure, sampled at the rising edge.
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            repeat ($urandom_range(0, 13)) @(negedge clk);
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid)
                @(posedge clk);
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result cell=%0d mag=%0d", $time,
                         out_ch.data.result_cell, out_ch.data.magnitude);
                error_count++;
            end
            else
            begin
                out_item_t exp_r;
                exp_r = expected_results.pop_front();
                if (out_ch.data.result_cell !== exp_r.result_cell)
                begin
                    $display("%0t: result_cell expected %0d actual %0d", $time,
                             exp_r.result_cell, out_ch.data.result_cell);
                    error_count++;
                end
                if (out_ch.data.magnitude !== exp_r.magnitude)
                begin
                    $display("%0t: magnitude expected %0d actual %0d", $time,
                             exp_r.magnitude, out_ch.data.magnitude);
                    error_count++;
                end
            end
            results_seen++;
            @(negedge clk);
            out_ch.ready <= 1'b0;
        end
    end

    initial
    begin
        #50ms;
        $display("Timeout");
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        error_count   = 0;
        items_sent    = 0;
        results_seen  = 0;
        for (int k = 0; k < ANTENNAS; k++)
        begin
            meas_re[k] = 0;
            meas_im[k] = 0;
        end
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        rst_n       = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random();
        drain_results();
        $display("Sent %0d transfers, checked %0d correlation results", items_sent,
                 results_seen);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
